FILE: hdl/base64_line_wrapped_encoder_core_assert.svh
// Assertion macros used by the encoder checker.
`ifndef BASE64_LINE_WRAPPED_ENCODER_CORE_ASSERT_SVH
`define BASE64_LINE_WRAPPED_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define B64LW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b64lw assertion failed");

// next-cycle implication, quiet during reset
`define B64LW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b64lw assertion failed");

`endif

FILE: hdl/b64lw_pkg.sv
package b64lw_pkg;

	localparam int BYTE_W = 8;
	localparam int CHAR_W = 7;
	localparam int GPL_W  = 6;
	localparam int GRP_MAX = 5;
	localparam int CNT_W  = $clog2(GRP_MAX + 1);
	localparam int IDX_W  = $clog2(GRP_MAX);

	localparam logic [CHAR_W-1:0] NL_CHAR  = 7'd10;
	localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;
	localparam logic [GPL_W-1:0]  GPL_RESET = 6'd18;

	// one encoded group: up to four characters plus a newline
	typedef struct packed {
		logic [GRP_MAX-1:0][CHAR_W-1:0] chars;
		logic [CNT_W-1:0]               cnt;
		logic                           eom;
	} grp_t;

	function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
		logic [CHAR_W-1:0] c;
		if (v < 6'd26) begin
			c = 7'd65 + 7'(v);
		end else if (v < 6'd52) begin
			c = 7'd97 + 7'(v - 6'd26);
		end else if (v < 6'd62) begin
			c = 7'd48 + 7'(v - 6'd52);
		end else if (v == 6'd62) begin
			c = 7'd43;
		end else begin
			c = 7'd47;
		end
		return c;
	endfunction

endpackage

FILE: hdl/b64lw_byte_if.sv
interface b64lw_byte_if;
	logic                          valid;
	logic                          ready;
	logic [b64lw_pkg::BYTE_W-1:0]  data_byte;
	logic                          end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

FILE: hdl/b64lw_char_if.sv
interface b64lw_char_if;
	logic                          valid;
	logic                          ready;
	logic [b64lw_pkg::CHAR_W-1:0]  out_char;
	logic                          last_of_run;
	logic                          message_done;

	modport source (output valid, output out_char, output last_of_run, output message_done,
		input ready);
	modport sink (input valid, input out_char, input last_of_run, input message_done,
		output ready);
endinterface

FILE: hdl/b64lw_encode.sv
module b64lw_encode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [b64lw_pkg::BYTE_W-1:0]  data_s1,
	input  logic                          eom_s1,
	input  logic [b64lw_pkg::GPL_W-1:0]   gpl,
	output b64lw_pkg::grp_t               grp
);
	import b64lw_pkg::*;

	logic [15:0]      pend_bits_q, pend_bits_n;
	logic [1:0]       pend_cnt_q, pend_cnt_n;
	logic [GPL_W-1:0] line_groups_q, line_groups_n;
	logic [23:0]      v;
	logic [23:0]      w;
	logic [GPL_W-1:0] lg1;
	logic             nl;

	always_comb begin
		v = {pend_bits_q, data_s1};
		w = (pend_cnt_q == 2'd0) ? {data_s1, 16'h0000} : {v[15:0], 8'h00};
		lg1 = line_groups_q + 6'd1;
		nl = 1'b0;
		grp = '0;
		grp.eom = eom_s1;
		pend_bits_n = pend_bits_q;
		pend_cnt_n = pend_cnt_q;
		line_groups_n = line_groups_q;
		grp.chars[4] = NL_CHAR;
		if (pend_cnt_q == 2'd2) begin
			grp.chars[0] = b64_char(v[23:18]);
			grp.chars[1] = b64_char(v[17:12]);
			grp.chars[2] = b64_char(v[11:6]);
			grp.chars[3] = b64_char(v[5:0]);
			nl = (lg1 >= gpl);
			grp.cnt = nl ? CNT_W'(5) : CNT_W'(4);
			line_groups_n = nl ? '0 : lg1;
			pend_bits_n = '0;
			pend_cnt_n = '0;
		end else if (eom_s1) begin
			grp.chars[0] = b64_char(w[23:18]);
			grp.chars[1] = b64_char(w[17:12]);
			grp.chars[2] = (pend_cnt_q == 2'd0) ? PAD_CHAR : b64_char(w[11:6]);
			grp.chars[3] = PAD_CHAR;
			nl = (line_groups_q != '0);
			grp.cnt = nl ? CNT_W'(5) : CNT_W'(4);
		end else begin
			pend_bits_n = v[15:0];
			pend_cnt_n = pend_cnt_q + 2'd1;
		end
		// message end returns everything to the reset state
		if (eom_s1) begin
			pend_bits_n = '0;
			pend_cnt_n = '0;
			line_groups_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q <= '0;
			line_groups_q <= '0;
		end else if (advance) begin
			pend_bits_q <= pend_bits_n;
			pend_cnt_q <= pend_cnt_n;
			line_groups_q <= line_groups_n;
		end
	end

endmodule

FILE: hdl/b64lw_serializer.sv
module b64lw_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  b64lw_pkg::grp_t   grp_in,
	output logic              free,
	b64lw_char_if.source      char_out
);
	import b64lw_pkg::*;

	grp_t             grp_s2;
	logic             valid_s2;
	logic [IDX_W-1:0] idx_q;
	logic             last;

	assign last = (CNT_W'(idx_q) == grp_s2.cnt - CNT_W'(1));
	assign free = !valid_s2 || (char_out.ready && last);

	assign char_out.valid = valid_s2;
	assign char_out.out_char = grp_s2.chars[idx_q];
	assign char_out.last_of_run = last;
	assign char_out.message_done = last && grp_s2.eom;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q <= '0;
		end else if (load && grp_in.cnt != '0) begin
			valid_s2 <= 1'b1;
			idx_q <= '0;
		end else if (valid_s2 && char_out.ready) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s2 <= grp_in;
		end
	end

endmodule

FILE: hdl/base64_line_wrapped_encoder_core.sv
// Base64 encoder with line wrapping.
// byte_in: one message byte per word, end_of_message set on the final byte.
// char_out: one ASCII character per word; last_of_run marks the final
//   character caused by a byte, message_done the final one of the message.
// cfg_we/cfg_wdata: groups per line (reset 18); write only while idle.
// A byte sits in the input register, is encoded into a whole group of up
// to five characters in a single pass, and the group register then hands
// them out one per cycle while the receiver is ready. First character of
// a group is valid once the group register has loaded it from the byte
// that completes it. Bytes that only fill the pending group pass at one per
// cycle; a group of four or five characters holds the character port until
// its last character is taken.
// The next byte is taken while the group is still being sent.
// Reset clears pending bytes, line count, both registers and restores the
// line length. If the receiver stalls, the current character holds and
// byte_in drops ready once a group-completing byte waits behind it.
module base64_line_wrapped_encoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [b64lw_pkg::GPL_W-1:0]   cfg_wdata,
	b64lw_byte_if.sink                    byte_in,
	b64lw_char_if.source                  char_out
);
	import b64lw_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              eom_s1;
	logic [GPL_W-1:0]  gpl_q;
	logic              s2_free;
	logic              advance;
	logic              grp_load;
	grp_t              grp;

	// a byte that only gathers never waits for the group register
	assign advance = valid_s1 && (s2_free || grp.cnt == '0);
	assign grp_load = advance && grp.cnt != '0;
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpl_q <= GPL_RESET;
		end else if (cfg_we) begin
			gpl_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.valid && byte_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			data_s1 <= byte_in.data_byte;
			eom_s1 <= byte_in.end_of_message;
		end
	end

	b64lw_encode u_encode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.data_s1 (data_s1),
		.eom_s1  (eom_s1),
		.gpl     (gpl_q),
		.grp     (grp)
	);

	b64lw_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (grp_load),
		.grp_in   (grp),
		.free     (s2_free),
		.char_out (char_out)
	);

endmodule

FILE: hdl/b64lw_checker.sv
`include "base64_line_wrapped_encoder_core_assert.svh"

module b64lw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [b64lw_pkg::CHAR_W-1:0]  out_char,
	input logic                          last_of_run,
	input logic                          message_done
);
	import b64lw_pkg::*;

	`B64LW_ASSERT_IMP(a_done_is_last, out_valid && message_done, last_of_run)
	`B64LW_ASSERT_IMP(a_newline_is_last, out_valid && out_char == NL_CHAR, last_of_run)
	// a run never pauses on the producer side once started
	`B64LW_ASSERT_NXT(a_run_continues, out_valid && out_ready && !last_of_run, out_valid)
	// padding runs to the end of the group, only a newline may follow it
	`B64LW_ASSERT_NXT(a_pad_pairs,
		out_valid && out_ready && out_char == PAD_CHAR && !last_of_run,
		out_valid && (out_char == PAD_CHAR || out_char == NL_CHAR))
	`B64LW_ASSERT_NXT(a_stall_holds, out_valid && !out_ready,
		out_valid && $stable(out_char))

endmodule

bind base64_line_wrapped_encoder_core b64lw_checker u_b64lw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (char_out.valid),
	.out_ready    (char_out.ready),
	.out_char     (char_out.out_char),
	.last_of_run  (char_out.last_of_run),
	.message_done (char_out.message_done)
);

FILE: tb/base64_line_wrapped_encoder_core_tb.sv
`timescale 1ns / 1ps

module base64_line_wrapped_encoder_core_tb;

	import b64lw_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DIR_N = 19;
	localparam int PHASES = 6;
	localparam int HOLD_CYCLES = 300;
	localparam string ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	localparam int SEND_IDLE [3] = '{24, 74, 0};
	localparam int RECV_IDLE [3] = '{74, 24, 0};
	localparam logic [GPL_W-1:0] LINE_LIMITS [PHASES] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd2};
	localparam int PHASE_LEN [PHASES] = '{50, 70, 40, 130, 60, 50};

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              done;
	} char_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [GPL_W-1:0] cfg_wdata;

	b64lw_byte_if byte_bus ();
	b64lw_char_if char_bus ();

	base64_line_wrapped_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_in   (byte_bus),
		.char_out  (char_bus)
	);

	// encoder state as predicted
	logic [15:0]      pend_bits;
	logic [1:0]       pend_cnt;
	logic [GPL_W-1:0] line_grp;
	logic [GPL_W-1:0] grp_limit;

	char_word_t group_chars [$];
	char_word_t encoded_q [$];

	int err_cnt = 0;
	int bytes_sent = 0;
	int chars_checked = 0;
	int cycle_cnt = 0;
	int idle_mode = 0;
	int hold_req = 0;

	// directed table: {end_of_message, data_byte}, typed text where obvious
	logic [8:0] dir_word [DIR_N] = '{
		{1'b0, 8'h4D}, {1'b0, 8'h61}, {1'b0, 8'h6E},
		{1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00},
		{1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF},
		{1'b0, 8'hFB}, {1'b0, 8'hEF}, {1'b0, 8'hBE},
		{1'b0, 8'h4D}, {1'b1, 8'h61},
		{1'b1, 8'h00},
		{1'b1, 8'hFF},
		{1'b0, 8'h4D}, {1'b0, 8'h61}, {1'b1, 8'h6E}
	};
	string dir_txt [DIR_N] = '{
		"", "", "TWFu",
		"", "", "AAAA",
		"", "", "////",
		"", "", "++++",
		"", "TWE=\n",
		"AA==",
		"/w==",
		"", "", "TWFu"
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
		return CHAR_W'(ALPHABET[v]);
	endfunction

	function automatic void add_char(input logic [CHAR_W-1:0] c);
		char_word_t w;
		w.ch = c;
		w.last = 1'b0;
		w.done = 1'b0;
		group_chars.push_back(w);
	endfunction

	// fills group_chars with the characters one byte causes
	function automatic void encode_byte(input logic [7:0] b, input logic e);
		logic [23:0] v;
		logic [23:0] w;
		int cnt;
		group_chars.delete();
		v = {pend_bits, b};
		cnt = int'(pend_cnt) + 1;
		if (cnt == 3) begin
			add_char(sextet_char(v[23:18]));
			add_char(sextet_char(v[17:12]));
			add_char(sextet_char(v[11:6]));
			add_char(sextet_char(v[5:0]));
			line_grp = line_grp + 1'b1;
			if (line_grp >= grp_limit) begin
				add_char(NL_CHAR);
				line_grp = '0;
			end
			pend_bits = '0;
			pend_cnt = '0;
		end else if (e) begin
			w = (cnt == 1) ? {b, 16'h0000} : {v[15:0], 8'h00};
			add_char(sextet_char(w[23:18]));
			add_char(sextet_char(w[17:12]));
			add_char((cnt == 1) ? PAD_CHAR : sextet_char(w[11:6]));
			add_char(PAD_CHAR);
			if (line_grp != 0)
				add_char(NL_CHAR);
		end else begin
			pend_bits = v[15:0];
			pend_cnt = 2'(cnt);
			return;
		end
		group_chars[group_chars.size() - 1].last = 1'b1;
		if (e) begin
			group_chars[group_chars.size() - 1].done = 1'b1;
			pend_bits = '0;
			pend_cnt = '0;
			line_grp = '0;
		end
	endfunction

	// offer one word, predict on acceptance; typed text overrides the prediction
	task automatic push_byte(input logic [7:0] b, input logic e, input string txt);
		char_word_t w;
		int k;
		if ($urandom_range(0, 99) < SEND_IDLE[idle_mode]) begin
			byte_bus.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < SEND_IDLE[idle_mode]);
		end
		byte_bus.valid <= 1'b1;
		byte_bus.data_byte <= b;
		byte_bus.end_of_message <= e;
		do @(posedge clk); while (!byte_bus.ready);
		bytes_sent++;
		encode_byte(b, e);
		if (txt.len() == 0) begin
			foreach (group_chars[k])
				encoded_q.push_back(group_chars[k]);
		end else begin
			for (k = 0; k < txt.len(); k++) begin
				w.ch = CHAR_W'(txt[k]);
				w.last = (k == txt.len() - 1);
				w.done = e && w.last;
				encoded_q.push_back(w);
			end
		end
		@(negedge clk);
	endtask

	task automatic write_line_limit(input logic [GPL_W-1:0] v);
		// a byte may still sit in the input register with nothing to show
		repeat (6) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		grp_limit = v;
	endtask

	// receiver: random stalls, plus one long hold on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		char_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				char_bus.ready <= 1'b0;
			end else begin
				char_bus.ready <= ($urandom_range(0, 99) >= RECV_IDLE[idle_mode]);
			end
		end
	end

	always @(posedge clk) begin
		char_word_t x;
		if (arst_n && char_bus.valid && char_bus.ready) begin
			chars_checked++;
			if (encoded_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected char word: expected none, got char %0d last %0b done %0b",
					$time, char_bus.out_char, char_bus.last_of_run, char_bus.message_done);
			end else begin
				x = encoded_q.pop_front();
				if (char_bus.out_char !== x.ch) begin
					err_cnt++;
					$display("%0t: out_char expected %0d got %0d", $time, x.ch, char_bus.out_char);
				end
				if (char_bus.last_of_run !== x.last) begin
					err_cnt++;
					$display("%0t: last_of_run expected %0b got %0b", $time, x.last,
						char_bus.last_of_run);
				end
				if (char_bus.message_done !== x.done) begin
					err_cnt++;
					$display("%0t: message_done expected %0b got %0b", $time, x.done,
						char_bus.message_done);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d chars still owed", cycle_cnt, encoded_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int p;
		int i;
		int r;
		int msg_left;
		logic [7:0] b;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		byte_bus.valid = 1'b0;
		byte_bus.data_byte = '0;
		byte_bus.end_of_message = 1'b0;
		pend_bits = '0;
		pend_cnt = '0;
		line_grp = '0;
		grp_limit = GPL_RESET;
		msg_left = 0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at the reset line length
		for (i = 0; i < DIR_N; i++)
			push_byte(dir_word[i][7:0], dir_word[i][8], dir_txt[i]);
		byte_bus.valid <= 1'b0;
		while (encoded_q.size() != 0) @(posedge clk);

		// random messages; phases may end mid-message, so the limit can drop mid-line
		for (p = 0; p < PHASES; p++) begin
			write_line_limit(LINE_LIMITS[p]);
			idle_mode = p / 2;
			if (p == 4)
				hold_req++;
			for (i = 0; i < PHASE_LEN[p]; i++) begin
				if (msg_left == 0) begin
					r = $urandom_range(0, 9);
					if (r < 6)
						msg_left = $urandom_range(1, 9);
					else if (r < 9)
						msg_left = $urandom_range(10, 60);
					else
						msg_left = $urandom_range(150, 220);
				end
				case ($urandom_range(0, 7))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom);
				endcase
				msg_left--;
				push_byte(b, msg_left == 0, "");
			end
			byte_bus.valid <= 1'b0;
			while (encoded_q.size() != 0) @(posedge clk);
		end

		repeat (10) @(posedge clk);

		$display("Encoded %0d bytes into %0d checked chars, %0d errors", bytes_sent,
			chars_checked, err_cnt);
		$display("Line lengths 18, 1, 32, 0, 63, 5, 2 groups; one long receiver hold");
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
